// ===== sv/polar_stereographic_to_pixel_defines.svh =====
// assertion macros for the polar stereographic projection block
// used by the port checker; depends on nothing
`ifndef POLAR_STEREOGRAPHIC_TO_PIXEL_DEFINES_SVH
`define POLAR_STEREOGRAPHIC_TO_PIXEL_DEFINES_SVH

// condition implies property in the same cycle
`define PSP_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle
`define PSP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/psp_pkg.sv =====
// shared constants, types and helpers for the polar stereographic projection block
// no dependencies
package psp_pkg;

    // fixed point formats
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int ANG_FRAC      = 24;
    localparam int ANG_SHIFT     = ANG_FRAC - FRAC_BITS;
    localparam int ANG_W         = 32;
    localparam int TRIG_W        = 32;
    localparam int TRIG_FRAC     = 30;
    localparam int ATAN_N        = 32;

    // port and register widths
    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int CM_W    = 25;
    localparam int SP_W    = 23;
    localparam int RAD_W   = 20;
    localparam int RES_W   = 24;
    localparam int PIX_W   = 32;
    localparam int MAP_W   = 16;
    localparam int DELTA_W = 26;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;
    localparam int WRAP_W  = DELTA_W + 1;

    // datapath widths
    localparam int A_W       = TRIG_W;
    localparam int C_W       = TRIG_W - 1;
    localparam int P_W       = A_W + C_W - TRIG_FRAC;
    localparam int T_W       = P_W + C_W - TRIG_FRAC;
    localparam int N_W       = T_W + RAD_W;
    localparam int DEN_W     = A_W + RES_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int QUOT_W    = 41;
    localparam int DIV_SHIFT = 2 * FRAC_BITS - 4;
    localparam int TOP_SHIFT = QUOT_W - DIV_SHIFT;
    localparam int SUM_W     = QUOT_W + 2;

    // register stages from input to output register
    localparam int PIPE_DEPTH = 2 + CORDIC_STAGES + 4 + (QUOT_W + 1) + 2;

    localparam logic signed [WRAP_W-1:0] DEG_90  = WRAP_W'(90 * (2 ** FRAC_BITS));
    localparam logic signed [WRAP_W-1:0] DEG_180 = WRAP_W'(180 * (2 ** FRAC_BITS));
    localparam logic signed [WRAP_W-1:0] DEG_360 = WRAP_W'(360 * (2 ** FRAC_BITS));
    localparam logic signed [LAT_W-1:0]  LAT_90  = LAT_W'(90 * (2 ** FRAC_BITS));

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [TRIG_W:0]   Q30_ONE     = (TRIG_W + 1)'(2 ** TRIG_FRAC);

    localparam logic [QUOT_W-1:0] QUOT_LIMIT = {1'b1, {(QUOT_W - 1){1'b0}}};
    localparam logic [QUOT_W-1:0] QUOT_CAP   = {1'b1, {(QUOT_W - 2){1'b0}}, 1'b1};

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W - 1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W - 1){1'b0}}};

    // register reset values
    localparam logic signed [CM_W-1:0]  CM_RESET     = 25'sd655360;
    localparam logic [SP_W-1:0]         SP_RESET     = 23'd3932160;
    localparam logic [RAD_W-1:0]        RAD_RESET    = 20'd101920;
    localparam logic [RES_W-1:0]        RES_RESET    = 24'd78558;
    localparam logic signed [PIX_W-1:0] POLE_X_RESET = 32'sd31985238;
    localparam logic signed [PIX_W-1:0] POLE_Y_RESET = -32'sd206309818;
    localparam logic [MAP_W-1:0]        MAP_W_RESET  = 16'd1000;
    localparam logic [MAP_W-1:0]        MAP_H_RESET  = 16'd750;

    // atan(2^-i) in degrees, 24 fractional bits
    localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_N] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    typedef enum logic [IDX_W-1:0] {
        REG_CM, REG_SP, REG_RAD, REG_RES, REG_POLE_X, REG_POLE_Y, REG_MAP_W, REG_MAP_H
    } reg_idx_t;

    // cordic start angle and the half-turn fold flag
    typedef struct packed {
        logic                    neg;
        logic signed [ANG_W-1:0] z;
    } ang_t;

    // per-item flags that ride beside the arithmetic
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic                      bad;
        logic                      sgn_x;
        logic                      sgn_y;
    } side_t;

    // wrap to [-180,180), fold into [-90,90], scale to cordic units
    function automatic ang_t angle_prep(input logic signed [WRAP_W-1:0] v);
        logic signed [WRAP_W-1:0] w;
        ang_t r;
        w = v;
        if (w >= DEG_180) begin
            w = w - DEG_360;
        end
        else if (w < -DEG_180) begin
            w = w + DEG_360;
        end
        r.neg = 1'b0;
        if (w > DEG_90) begin
            w = w - DEG_180;
            r.neg = 1'b1;
        end
        else if (w < -DEG_90) begin
            w = w + DEG_180;
            r.neg = 1'b1;
        end
        r.z = ANG_W'(w) <<< ANG_SHIFT;
        return r;
    endfunction

endpackage

// ===== sv/psp_cordic.sv =====
// pipelined rotation cordic, one micro-rotation per register stage
// depends on psp_pkg
module psp_cordic (
    input  logic                               clk,
    input  logic                               en,
    input  psp_pkg::ang_t                      ang_in,
    output logic signed [psp_pkg::TRIG_W-1:0]  sin_out,
    output logic signed [psp_pkg::TRIG_W-1:0]  cos_out
);

    logic signed [psp_pkg::TRIG_W-1:0] x_reg [psp_pkg::CORDIC_STAGES];
    logic signed [psp_pkg::TRIG_W-1:0] y_reg [psp_pkg::CORDIC_STAGES];
    logic signed [psp_pkg::ANG_W-1:0]  z_reg [psp_pkg::CORDIC_STAGES];
    logic                              neg_reg [psp_pkg::CORDIC_STAGES];

    for (genvar g = 0; g < psp_pkg::CORDIC_STAGES; g++) begin : g_stage
        logic signed [psp_pkg::TRIG_W-1:0] x_in, y_in, x_next, y_next;
        logic signed [psp_pkg::ANG_W-1:0]  z_in, z_next;
        logic                              neg_in;

        // stage input: start vector or previous stage
        if (g == 0) begin : g_first
            assign x_in   = psp_pkg::CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = ang_in.z;
            assign neg_in = ang_in.neg;
        end
        else begin : g_rest
            assign x_in   = x_reg[g-1];
            assign y_in   = y_reg[g-1];
            assign z_in   = z_reg[g-1];
            assign neg_in = neg_reg[g-1];
        end

        // one micro-rotation toward zero residual angle
        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> g);
                y_next = y_in + (x_in >>> g);
                z_next = z_in - psp_pkg::ATAN_TABLE[g];
            end
            else
            begin
                x_next = x_in + (y_in >>> g);
                y_next = y_in - (x_in >>> g);
                z_next = z_in + psp_pkg::ATAN_TABLE[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]   <= x_next;
                y_reg[g]   <= y_next;
                z_reg[g]   <= z_next;
                neg_reg[g] <= neg_in;
            end
        end
    end

    // undo the half-turn fold
    assign sin_out = neg_reg[psp_pkg::CORDIC_STAGES-1] ? -y_reg[psp_pkg::CORDIC_STAGES-1]
                                                        :  y_reg[psp_pkg::CORDIC_STAGES-1];
    assign cos_out = neg_reg[psp_pkg::CORDIC_STAGES-1] ? -x_reg[psp_pkg::CORDIC_STAGES-1]
                                                        :  x_reg[psp_pkg::CORDIC_STAGES-1];

endmodule

// ===== sv/psp_div.sv =====
// pipelined restoring divider, floor(num * 2^DIV_SHIFT / den), one quotient bit per stage
// depends on psp_pkg
module psp_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [psp_pkg::N_W-1:0]       num,
    input  logic [psp_pkg::DEN_W-1:0]     den,
    output logic [psp_pkg::QUOT_W-1:0]    quot,
    output logic                          big
);

    logic [psp_pkg::REM_W-1:0]     rem_reg  [psp_pkg::QUOT_W+1];
    logic [psp_pkg::DEN_W-1:0]     den_reg  [psp_pkg::QUOT_W+1];
    logic [psp_pkg::TOP_SHIFT-1:0] feed_reg [psp_pkg::QUOT_W+1];
    logic [psp_pkg::QUOT_W-1:0]    q_reg    [psp_pkg::QUOT_W+1];
    logic                          big_reg  [psp_pkg::QUOT_W+1];

    // load: top bits start the remainder, quotient too wide if they reach den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= psp_pkg::REM_W'(num[psp_pkg::N_W-1:psp_pkg::TOP_SHIFT]);
            big_reg[0]  <= psp_pkg::DEN_W'(num[psp_pkg::N_W-1:psp_pkg::TOP_SHIFT]) >= den;
            feed_reg[0] <= num[psp_pkg::TOP_SHIFT-1:0];
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
        end
    end

    for (genvar g = 1; g <= psp_pkg::QUOT_W; g++) begin : g_step
        logic [psp_pkg::REM_W-1:0] shifted;
        logic                      take;

        // shift in the next numerator bit and try the subtract
        always_comb
        begin
            shifted = {rem_reg[g-1][psp_pkg::DEN_W-1:0],
                       feed_reg[g-1][psp_pkg::TOP_SHIFT-1]};
            take    = shifted >= {1'b0, den_reg[g-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? shifted - {1'b0, den_reg[g-1]} : shifted;
                q_reg[g]    <= {q_reg[g-1][psp_pkg::QUOT_W-2:0], take};
                feed_reg[g] <= {feed_reg[g-1][psp_pkg::TOP_SHIFT-2:0], 1'b0};
                den_reg[g]  <= den_reg[g-1];
                big_reg[g]  <= big_reg[g-1];
            end
        end
    end

    assign quot = q_reg[psp_pkg::QUOT_W];
    assign big  = big_reg[psp_pkg::QUOT_W];

endmodule

// ===== sv/polar_stereographic_to_pixel.sv =====
// polar stereographic projection of latitude/longitude beats to image pixels
// depends on psp_pkg, psp_cordic, psp_div
//
// usage
//   input channel: in_valid/in_stall carry latitude and longitude; a beat is
//   taken when in_valid is high and in_stall is low.
//   output channel: out_valid/out_stall carry pixel_x, pixel_y, inside_map,
//   up_bearing and overflow, one result beat for every input beat, in order.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. write registers only while no beat is in flight.
//   pipeline: two prep stages, a 24-stage cordic, four multiply stages, a
//   42-stage divider and two output stages lie between input beat and result
//   beat. throughput: one beat per cycle while no result waits under out_stall,
//   set by the fully pipelined cordic and divider.
//   stall: the whole pipeline holds while a result waits under out_stall;
//   in_stall is raised in that cycle, so nothing is lost or repeated.
//   reset: the pipeline empties and the registers take their default
//   projection (60 deg standard parallel, 10 deg east central meridian).
module polar_stereographic_to_pixel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [psp_pkg::LAT_W-1:0]    latitude,
    input  logic signed [psp_pkg::LON_W-1:0]    longitude,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [psp_pkg::PIX_W-1:0]    pixel_x,
    output logic signed [psp_pkg::PIX_W-1:0]    pixel_y,
    output logic                                inside_map,
    output logic signed [psp_pkg::DELTA_W-1:0]  up_bearing,
    output logic                                overflow,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psp_pkg::IDX_W-1:0]           cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]           cfg_data
);

    // configuration registers
    logic signed [psp_pkg::CM_W-1:0]  cm_reg;
    logic [psp_pkg::SP_W-1:0]         sp_reg;
    logic [psp_pkg::RAD_W-1:0]        rad_reg;
    logic [psp_pkg::RES_W-1:0]        res_reg;
    logic signed [psp_pkg::PIX_W-1:0] pole_x_reg;
    logic signed [psp_pkg::PIX_W-1:0] pole_y_reg;
    logic [psp_pkg::MAP_W-1:0]        map_w_reg;
    logic [psp_pkg::MAP_W-1:0]        map_h_reg;

    logic                             en;
    logic [psp_pkg::PIPE_DEPTH-1:0]   vld_reg;

    // prep stages
    logic signed [psp_pkg::LAT_W-1:0]   lat_a_reg;
    logic signed [psp_pkg::DELTA_W-1:0] delta_a_reg;
    logic                               pole_a_reg;
    psp_pkg::ang_t                      ang_sp_reg, ang_lat_reg, ang_d_reg;
    psp_pkg::side_t                     side_b_reg;

    // cordic outputs and side line
    logic signed [psp_pkg::TRIG_W-1:0]  sin_sp, sin_l, cos_l, sin_d, cos_d;
    psp_pkg::side_t                     side_c_reg [psp_pkg::CORDIC_STAGES];

    // multiply stages
    logic signed [psp_pkg::TRIG_W:0]    a_sum, d_sum;
    logic [psp_pkg::A_W-1:0]            a_reg, d_reg;
    logic [psp_pkg::C_W-1:0]            c_reg, magx_reg, magy_reg;
    psp_pkg::side_t                     side_m1_reg, side_m1_next;
    logic [psp_pkg::A_W+psp_pkg::C_W-1:0] ac_prod;
    logic [psp_pkg::P_W-1:0]            p_reg;
    logic [psp_pkg::DEN_W-1:0]          den_m2_reg, den_m3_reg, den_m4_reg;
    logic [psp_pkg::C_W-1:0]            magx_m2_reg, magy_m2_reg;
    psp_pkg::side_t                     side_m2_next;
    psp_pkg::side_t                     side_m2_reg, side_m3_reg, side_m4_reg;
    logic [psp_pkg::P_W+psp_pkg::C_W-1:0] px_prod, py_prod;
    logic [psp_pkg::T_W-1:0]            tx_reg, ty_reg;
    logic [psp_pkg::N_W-1:0]            nx_reg, ny_reg;

    // divider outputs and side line
    logic [psp_pkg::QUOT_W-1:0]         qx, qy, qx_cap, qy_cap;
    logic                               qx_big, qy_big;
    psp_pkg::side_t                     side_d_reg [psp_pkg::QUOT_W+1];

    // final stages
    logic signed [psp_pkg::SUM_W-1:0]   offx, offy;
    logic signed [psp_pkg::SUM_W-1:0]   sum_x_reg, sum_y_reg;
    psp_pkg::side_t                     side_f1_reg;
    logic signed [psp_pkg::PIX_W-1:0]   ox, oy;
    logic                               ovf, sat_x, sat_y;
    logic signed [psp_pkg::PIX_W-1:0]   pixel_x_reg, pixel_y_reg;
    logic                               inside_reg, overflow_reg;
    logic signed [psp_pkg::DELTA_W-1:0] bearing_reg;

    // saturate a sum to the 32 bit pixel range
    function automatic logic signed [psp_pkg::PIX_W-1:0] sat_pix(
        input logic signed [psp_pkg::SUM_W-1:0] v
    );
        logic signed [psp_pkg::PIX_W-1:0] r;
        if (v > psp_pkg::SUM_W'(psp_pkg::PIX_MAX))
        begin
            r = psp_pkg::PIX_MAX;
        end
        else if (v < psp_pkg::SUM_W'(psp_pkg::PIX_MIN))
        begin
            r = psp_pkg::PIX_MIN;
        end
        else
        begin
            r = psp_pkg::PIX_W'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg     <= psp_pkg::CM_RESET;
            sp_reg     <= psp_pkg::SP_RESET;
            rad_reg    <= psp_pkg::RAD_RESET;
            res_reg    <= psp_pkg::RES_RESET;
            pole_x_reg <= psp_pkg::POLE_X_RESET;
            pole_y_reg <= psp_pkg::POLE_Y_RESET;
            map_w_reg  <= psp_pkg::MAP_W_RESET;
            map_h_reg  <= psp_pkg::MAP_H_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (psp_pkg::reg_idx_t'(cfg_index))
                psp_pkg::REG_CM:     cm_reg     <= cfg_data[psp_pkg::CM_W-1:0];
                psp_pkg::REG_SP:     sp_reg     <= cfg_data[psp_pkg::SP_W-1:0];
                psp_pkg::REG_RAD:    rad_reg    <= cfg_data[psp_pkg::RAD_W-1:0];
                psp_pkg::REG_RES:    res_reg    <= cfg_data[psp_pkg::RES_W-1:0];
                psp_pkg::REG_POLE_X: pole_x_reg <= cfg_data[psp_pkg::PIX_W-1:0];
                psp_pkg::REG_POLE_Y: pole_y_reg <= cfg_data[psp_pkg::PIX_W-1:0];
                psp_pkg::REG_MAP_W:  map_w_reg  <= cfg_data[psp_pkg::MAP_W-1:0];
                psp_pkg::REG_MAP_H:  map_h_reg  <= cfg_data[psp_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: hold everything while a finished beat is stalled
    assign en       = !(vld_reg[psp_pkg::PIPE_DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[psp_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    // stage a: clamp latitude, bearing difference, south pole check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_a_reg   <= (latitude > psp_pkg::LAT_90) ? psp_pkg::LAT_90 : latitude;
            delta_a_reg <= {longitude[psp_pkg::LON_W-1], longitude}
                         - {cm_reg[psp_pkg::CM_W-1], cm_reg};
            pole_a_reg  <= latitude <= -psp_pkg::LAT_90;
        end
    end

    // stage b: wrap and fold the three angles
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_sp_reg       <= psp_pkg::angle_prep(psp_pkg::WRAP_W'(sp_reg));
            ang_lat_reg      <= psp_pkg::angle_prep(psp_pkg::WRAP_W'(lat_a_reg));
            ang_d_reg        <= psp_pkg::angle_prep(psp_pkg::WRAP_W'(delta_a_reg));
            side_b_reg.delta <= delta_a_reg;
            side_b_reg.bad   <= pole_a_reg;
            side_b_reg.sgn_x <= 1'b0;
            side_b_reg.sgn_y <= 1'b0;
        end
    end

    psp_cordic u_cordic_sp (
        .clk     (clk),
        .en      (en),
        .ang_in  (ang_sp_reg),
        .sin_out (sin_sp),
        .cos_out ()
    );

    psp_cordic u_cordic_lat (
        .clk     (clk),
        .en      (en),
        .ang_in  (ang_lat_reg),
        .sin_out (sin_l),
        .cos_out (cos_l)
    );

    psp_cordic u_cordic_d (
        .clk     (clk),
        .en      (en),
        .ang_in  (ang_d_reg),
        .sin_out (sin_d),
        .cos_out (cos_d)
    );

    // side line beside the cordic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_c_reg[0] <= side_b_reg;
            for (int i = 1; i < psp_pkg::CORDIC_STAGES; i++)
            begin
                side_c_reg[i] <= side_c_reg[i-1];
            end
        end
    end

    // stage m1: 1 + sin terms, clamped cosine, magnitudes and signs
    always_comb
    begin
        a_sum        = psp_pkg::Q30_ONE + (psp_pkg::TRIG_W + 1)'(sin_sp);
        d_sum        = psp_pkg::Q30_ONE + (psp_pkg::TRIG_W + 1)'(sin_l);
        side_m1_next = side_c_reg[psp_pkg::CORDIC_STAGES-1];
        side_m1_next.sgn_x = sin_d[psp_pkg::TRIG_W-1];
        side_m1_next.sgn_y = cos_d[psp_pkg::TRIG_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg       <= a_sum[psp_pkg::TRIG_W] ? '0 : a_sum[psp_pkg::A_W-1:0];
            d_reg       <= d_sum[psp_pkg::TRIG_W] ? '0 : d_sum[psp_pkg::A_W-1:0];
            c_reg       <= cos_l[psp_pkg::TRIG_W-1] ? '0 : cos_l[psp_pkg::C_W-1:0];
            magx_reg    <= sin_d[psp_pkg::TRIG_W-1] ? psp_pkg::C_W'(-sin_d)
                                                    : psp_pkg::C_W'(sin_d);
            magy_reg    <= cos_d[psp_pkg::TRIG_W-1] ? psp_pkg::C_W'(-cos_d)
                                                    : psp_pkg::C_W'(cos_d);
            side_m1_reg <= side_m1_next;
        end
    end

    // stage m2: scale factor and divisor, zero divisor check
    assign ac_prod = a_reg * c_reg;

    always_comb
    begin
        side_m2_next     = side_m1_reg;
        side_m2_next.bad = side_m1_reg.bad || (d_reg == '0) || (res_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg       <= ac_prod[psp_pkg::A_W+psp_pkg::C_W-1:psp_pkg::TRIG_FRAC];
            den_m2_reg  <= d_reg * res_reg;
            magx_m2_reg <= magx_reg;
            magy_m2_reg <= magy_reg;
            side_m2_reg <= side_m2_next;
        end
    end

    // stage m3: projected distance times sin and cos
    assign px_prod = p_reg * magx_m2_reg;
    assign py_prod = p_reg * magy_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg      <= px_prod[psp_pkg::P_W+psp_pkg::C_W-1:psp_pkg::TRIG_FRAC];
            ty_reg      <= py_prod[psp_pkg::P_W+psp_pkg::C_W-1:psp_pkg::TRIG_FRAC];
            den_m3_reg  <= den_m2_reg;
            side_m3_reg <= side_m2_reg;
        end
    end

    // stage m4: times sphere radius
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg      <= tx_reg * rad_reg;
            ny_reg      <= ty_reg * rad_reg;
            den_m4_reg  <= den_m3_reg;
            side_m4_reg <= side_m3_reg;
        end
    end

    psp_div u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (nx_reg),
        .den  (den_m4_reg),
        .quot (qx),
        .big  (qx_big)
    );

    psp_div u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (ny_reg),
        .den  (den_m4_reg),
        .quot (qy),
        .big  (qy_big)
    );

    // side line beside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d_reg[0] <= side_m4_reg;
            for (int i = 1; i <= psp_pkg::QUOT_W; i++)
            begin
                side_d_reg[i] <= side_d_reg[i-1];
            end
        end
    end

    // stage f1: cap huge quotients, apply sign, add pole position
    always_comb
    begin
        qx_cap = (qx_big || qx > psp_pkg::QUOT_LIMIT) ? psp_pkg::QUOT_CAP : qx;
        qy_cap = (qy_big || qy > psp_pkg::QUOT_LIMIT) ? psp_pkg::QUOT_CAP : qy;
        offx   = side_d_reg[psp_pkg::QUOT_W].sgn_x ? -psp_pkg::SUM_W'(qx_cap)
                                                  :  psp_pkg::SUM_W'(qx_cap);
        offy   = side_d_reg[psp_pkg::QUOT_W].sgn_y ? -psp_pkg::SUM_W'(qy_cap)
                                                  :  psp_pkg::SUM_W'(qy_cap);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg   <= psp_pkg::SUM_W'(pole_x_reg) + offx;
            sum_y_reg   <= psp_pkg::SUM_W'(pole_y_reg) + offy;
            side_f1_reg <= side_d_reg[psp_pkg::QUOT_W];
        end
    end

    // stage f2: saturate, override on bad input, map bounds
    always_comb
    begin
        sat_x = (sum_x_reg > psp_pkg::SUM_W'(psp_pkg::PIX_MAX))
             || (sum_x_reg < psp_pkg::SUM_W'(psp_pkg::PIX_MIN));
        sat_y = (sum_y_reg > psp_pkg::SUM_W'(psp_pkg::PIX_MAX))
             || (sum_y_reg < psp_pkg::SUM_W'(psp_pkg::PIX_MIN));
        if (side_f1_reg.bad)
        begin
            ox  = psp_pkg::PIX_MAX;
            oy  = psp_pkg::PIX_MAX;
            ovf = 1'b1;
        end
        else
        begin
            ox  = sat_pix(sum_x_reg);
            oy  = sat_pix(sum_y_reg);
            ovf = sat_x || sat_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_x_reg  <= ox;
            pixel_y_reg  <= oy;
            overflow_reg <= ovf;
            bearing_reg  <= side_f1_reg.delta;
            inside_reg   <= !ovf && !ox[psp_pkg::PIX_W-1] && !oy[psp_pkg::PIX_W-1]
                         && ($unsigned(ox) < {map_w_reg, {psp_pkg::FRAC_BITS{1'b0}}})
                         && ($unsigned(oy) < {map_h_reg, {psp_pkg::FRAC_BITS{1'b0}}});
        end
    end

    assign out_valid  = vld_reg[psp_pkg::PIPE_DEPTH-1];
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign inside_map = inside_reg;
    assign up_bearing = bearing_reg;
    assign overflow   = overflow_reg;

endmodule

// ===== sv/psp_checker.sv =====
// port-level checks for the polar stereographic projection block, bound to the top level
// depends on polar_stereographic_to_pixel_defines.svh and polar_stereographic_to_pixel
`include "polar_stereographic_to_pixel_defines.svh"

module psp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [31:0]          pixel_x,
    input logic signed [31:0]          pixel_y,
    input logic                        inside_map,
    input logic                        overflow
);

    // input only backs up behind a stalled result
    `PSP_ASSERT_SAME(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output stall")

    // a stalled result beat holds
    `PSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(overflow), "stalled result changed")

    // overflow excludes the map
    `PSP_ASSERT_SAME(a_ovf_outside, clk, rst_n, out_valid && overflow, !inside_map, "inside_map with overflow")

    // overflow always shows a saturated coordinate
    `PSP_ASSERT_SAME(a_ovf_saturated, clk, rst_n, out_valid && overflow, pixel_x == 32'sh7fffffff || pixel_x == 32'sh80000000 || pixel_y == 32'sh7fffffff || pixel_y == 32'sh80000000, "overflow without saturated pixel")

endmodule

bind polar_stereographic_to_pixel psp_checker u_psp_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the polar stereographic projection block
// depends on psp_pkg and polar_stereographic_to_pixel; beats are predicted in a scoreboard class
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 90;
    localparam int LONG_HOLD = 300;
    localparam int DEG = 65536;

    // atan(2^-i) in degrees with 24 fractional bits
    localparam longint ARCTAN [32] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        bit [31:0] px;
        bit [31:0] py;
        bit        on_map;
        bit [25:0] bearing;
        bit        ovf;
    } pixel_beat_t;

    // projection predictor and the queue of pixels still owed by the block
    class pixel_scoreboard;
        longint cm, sp, rad, res, pole_x, pole_y, map_w, map_h;
        pixel_beat_t owed[$];
        int n_checked, n_bad;

        function new();
            cm = 655360; sp = 3932160; rad = 101920; res = 78558;
            pole_x = 31985238; pole_y = -206309818; map_w = 1000; map_h = 750;
        endfunction

        function void set_reg(psp_pkg::reg_idx_t idx, bit [31:0] v);
            case (idx)
                psp_pkg::REG_CM:     cm = longint'(signed'(v[24:0]));
                psp_pkg::REG_SP:     sp = longint'(v[22:0]);
                psp_pkg::REG_RAD:    rad = longint'(v[19:0]);
                psp_pkg::REG_RES:    res = longint'(v[23:0]);
                psp_pkg::REG_POLE_X: pole_x = longint'(signed'(v));
                psp_pkg::REG_POLE_Y: pole_y = longint'(signed'(v));
                psp_pkg::REG_MAP_W:  map_w = longint'(v[15:0]);
                default:             map_h = longint'(v[15:0]);
            endcase
        endfunction

        // rotation cordic, returns Q2.30 sin and cos
        function void sincos(longint ang, output longint sn, output longint cs);
            longint a, x, y, z, dx, dy;
            bit flip;
            a = (ang * 256) % (longint'(360) << 24);
            flip = 0;
            if (a >= (longint'(180) << 24)) a -= longint'(360) << 24;
            else if (a < -(longint'(180) << 24)) a += longint'(360) << 24;
            if (a > (longint'(90) << 24)) begin a -= longint'(180) << 24; flip = 1; end
            else if (a < -(longint'(90) << 24)) begin a += longint'(180) << 24; flip = 1; end
            x = 652032874; y = 0; z = a;
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin x -= dx; y += dy; z -= ARCTAN[i]; end
                else begin x += dx; y -= dy; z += ARCTAN[i]; end
            end
            if (flip) begin x = -x; y = -y; end
            sn = y;
            cs = x;
        endfunction

        // floor(n * 2^28 / d) with the cap just above 2^40
        function longint div_capped(bit [63:0] n, bit [63:0] d);
            bit [63:0] q, r;
            bit [63:0] cap;
            cap = 64'd1 << 40;
            q = n / d;
            r = n % d;
            if (q > cap) return longint'(cap + 1);
            for (int k = 0; k < 28; k++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= d) begin r -= d; q++; end
                if (q > cap) return longint'(cap + 1);
            end
            return longint'(q);
        endfunction

        function longint axis_offset(longint p, longint trig, longint den);
            bit [63:0] mag, t;
            longint q;
            mag = trig < 0 ? -trig : trig;
            t = (64'(p) * mag) >> 30;
            q = div_capped(t * 64'(rad), 64'(den));
            return trig < 0 ? -q : q;
        endfunction

        function longint clamp32(longint v, inout bit ovf);
            if (v > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function void note_input(logic signed [23:0] lat_in, logic signed [24:0] lon_in);
            longint lat, delta, s_sp, c_sp, s_l, c_l, s_d, c_d, a, c, d, ox, oy, p;
            bit ovf;
            pixel_beat_t e;
            lat = lat_in;
            delta = longint'(lon_in) - cm;
            ovf = 0;
            if (lat > 90 * DEG) lat = 90 * DEG;
            sincos(sp, s_sp, c_sp);
            sincos(lat, s_l, c_l);
            sincos(delta, s_d, c_d);
            a = (longint'(1) << 30) + s_sp; if (a < 0) a = 0;
            c = c_l < 0 ? 0 : c_l;
            d = (longint'(1) << 30) + s_l; if (d < 0) d = 0;
            if (lat <= -90 * DEG || d == 0 || res == 0)
            begin
                ovf = 1;
                ox = 64'sd2147483647;
                oy = 64'sd2147483647;
            end
            else
            begin
                p = longint'((64'(a) * 64'(c)) >> 30);
                ox = clamp32(pole_x + axis_offset(p, s_d, d * res), ovf);
                oy = clamp32(pole_y + axis_offset(p, c_d, d * res), ovf);
            end
            e.px = ox[31:0];
            e.py = oy[31:0];
            e.on_map = !ovf && ox >= 0 && ox < map_w * DEG && oy >= 0 && oy < map_h * DEG;
            e.bearing = delta[25:0];
            e.ovf = ovf;
            owed.push_back(e);
        endfunction

        function void check_result(pixel_beat_t got);
            pixel_beat_t e;
            n_checked++;
            if (owed.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result beat x=%h y=%h", got.px, got.py);
                return;
            end
            e = owed.pop_front();
            if (e != got)
            begin
                n_bad++;
                if (n_bad <= 10)
                begin
                    $display("mismatch: exp x=%h y=%h in=%0d brg=%h ovf=%0d",
                        e.px, e.py, e.on_map, e.bearing, e.ovf);
                    $display("          got x=%h y=%h in=%0d brg=%h ovf=%0d",
                        got.px, got.py, got.on_map, got.bearing, got.ovf);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [psp_pkg::LAT_W-1:0] latitude;
    logic signed [psp_pkg::LON_W-1:0] longitude;
    logic signed [psp_pkg::PIX_W-1:0] pixel_x, pixel_y;
    logic inside_map, overflow;
    logic signed [psp_pkg::DELTA_W-1:0] up_bearing;
    logic cfg_valid, cfg_ready;
    logic [psp_pkg::IDX_W-1:0] cfg_index;
    logic [psp_pkg::CFG_W-1:0] cfg_data;

    pixel_scoreboard sb;
    bit idling_on;
    bit hold_req;
    int n_sent, n_cfg;
    int unsigned cycles;

    polar_stereographic_to_pixel u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .latitude(latitude), .longitude(longitude),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .inside_map(inside_map),
        .up_bearing(up_bearing), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // result beat checking
    always @(posedge clk)
    begin
        pixel_beat_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.px = pixel_x;
            got.py = pixel_y;
            got.on_map = inside_map;
            got.bearing = up_bearing;
            got.ovf = overflow;
            sb.check_result(got);
        end
    end

    // receiver stall bursts and the one long hold
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall = 1'b0;
                hold_req = 0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // register write, called at a falling edge
    task automatic write_reg(psp_pkg::reg_idx_t idx, bit [31:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(int cm, int sp, int rad, int res, int px, int py, int mw, int mh);
        write_reg(psp_pkg::REG_CM, cm);
        write_reg(psp_pkg::REG_SP, sp);
        write_reg(psp_pkg::REG_RAD, rad);
        write_reg(psp_pkg::REG_RES, res);
        write_reg(psp_pkg::REG_POLE_X, px);
        write_reg(psp_pkg::REG_POLE_Y, py);
        write_reg(psp_pkg::REG_MAP_W, mw);
        write_reg(psp_pkg::REG_MAP_H, mh);
    endtask

    // one point beat, entered and left at a falling edge
    task automatic send_point(int lat, int lon);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1'b1;
        latitude = psp_pkg::LAT_W'(lat);
        longitude = psp_pkg::LON_W'(lon);
        do @(posedge clk); while (in_stall);
        sb.note_input(latitude, longitude);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_points(int n);
        int lat, lon;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: begin lat = $urandom; lon = $urandom; end
                1: lat = $urandom_range(0, 1) ? 90 * DEG : -90 * DEG + $urandom_range(0, 3);
                default: lat = int'($urandom_range(0, 2 * 5898240)) - 5898240;
            endcase
            if ($urandom_range(0, 9) != 0)
                lon = int'($urandom_range(0, 2 * 11796480)) - 11796480;
            send_point(lat, lon);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.owed.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        latitude = '0;
        longitude = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idling_on = 1;
        hold_req = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed points under the reset projection
        send_point(0, 0);
        send_point(90 * DEG, 10 * DEG);
        send_point(8388607, 0);
        send_point(-90 * DEG, 0);
        send_point(-8388608, 5 * DEG);
        send_point(-90 * DEG + 1, 0);
        send_point(60 * DEG, 11796480);
        send_point(60 * DEG, -11796480);
        send_point(45 * DEG, 16777215);
        send_point(45 * DEG, -16777216);
        send_point(70 * DEG, 10 * DEG);
        send_point(70 * DEG, 100 * DEG);
        send_point(70 * DEG, -80 * DEG);
        send_point(70 * DEG, 190 * DEG);
        send_point(-45 * DEG, 10 * DEG);
        send_point(5898240, -11796480);
        send_point(-5898240, 11796480);
        send_point(55 * DEG, 5 * DEG);
        send_point(-1, 1);
        send_random_points(120);
        drain();

        // extremes: west meridian, equator parallel, largest radius, finest pixel
        write_all(-11796480, 0, 1048575, 1, 32'h8000_0000, 32'h7fff_ffff, 65535, 65535);
        send_random_points(130);
        drain();

        // extremes: east meridian, pole parallel, smallest radius, coarsest pixel
        write_all(11796480, 5898240, 1, 16777215, 32'h7fff_ffff, 32'h8000_0000, 1, 1);
        send_random_points(130);
        drain();

        // long receiver hold while points keep coming
        write_all(0, 70 * DEG, 101920, 78558, 500 * DEG, 400 * DEG, 1000, 800);
        hold_req = 1;
        send_random_points(150);
        drain();

        // random projections
        for (int ph = 0; ph < 2; ph++)
        begin
            write_all(int'($urandom_range(0, 2 * 11796480)) - 11796480,
                $urandom_range(0, 5898240), $urandom_range(1, 1048575),
                $urandom_range(1, 16777215), $urandom, $urandom,
                $urandom_range(1, 65535), $urandom_range(1, 65535));
            send_random_points(130);
            drain();
        end

        // closing stretch at full rate under the reset projection values
        idling_on = 0;
        write_all(655360, 3932160, 101920, 78558, 31985238, -206309818, 1000, 750);
        send_random_points(140);
        drain();

        $display("%0d points sent over 7 projections, %0d register writes, %0d results checked",
            n_sent, n_cfg, sb.n_checked);
        $display("%0d mismatches", sb.n_bad);
        if (sb.n_bad == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
